[hw/rtl/alw_pkg.sv]
// adaptive lookahead window: shared types and constants
// used by alw_hist, alw_cdiv, the top module and the bench, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package alw_pkg;

  localparam int TIME_BITS  = 64;
  localparam int FIELD_BITS = 32;
  localparam int WIDTH_BITS = 59;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = WIDTH_BITS'(1) << (WIDTH_BITS - 1);

  localparam int SCALE    = 100;
  localparam int THR_LOW  = 33;
  localparam int THR_MID  = 66;
  localparam int THR_HIGH = 95;
  localparam int PROD_EXTRA = 7;

  localparam int DIV_LANES    = 2;
  localparam int DIV_WORD     = 64;
  localparam int DIV_STEP     = 8;
  localparam int DIV_CYCLES   = DIV_WORD / DIV_STEP;
  localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);
  localparam int REM_BITS     = 7;
  localparam int DOWN_BIAS    = 99;
  localparam logic [REM_BITS-1:0] DIV_CONST [DIV_LANES] = '{7'd100, 7'd101};
  localparam int LANE_UP   = 0;
  localparam int LANE_DOWN = 1;

  typedef struct packed {
    logic rd;
    logic upd;
  } hist_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/alw_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module alw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/alw_hist.sv]
// count history ring: ram of past rounds, valid bits, slot pointer, running sums
// depends on alw_pkg and alw_ram
`timescale 1ns / 1ps
`default_nettype none

module alw_hist #(
  parameter int HISTORY_DEPTH = 16,
  parameter int COUNT_BITS    = 32,
  parameter int TOTAL_BITS    = COUNT_BITS + $clog2(HISTORY_DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire alw_pkg::hist_ctrl_t     ctrl_i,
  input  wire logic [COUNT_BITS-1:0]   exec_count_i,
  input  wire logic [COUNT_BITS-1:0]   commit_count_i,
  output logic      [TOTAL_BITS-1:0]   exec_total_o,
  output logic      [TOTAL_BITS-1:0]   commit_total_o,
  output logic      [TOTAL_BITS-1:0]   commit_before_o
);

  localparam int PTR_BITS = $clog2(HISTORY_DEPTH);

  logic [PTR_BITS-1:0]      ptr_q, ptr_d;
  logic [HISTORY_DEPTH-1:0] valid_q, valid_d;
  logic                     old_valid_q, old_valid_d;
  logic [TOTAL_BITS-1:0]    exec_total_q, exec_total_d;
  logic [TOTAL_BITS-1:0]    commit_total_q, commit_total_d;
  logic [TOTAL_BITS-1:0]    commit_before_q, commit_before_d;
  logic [2*COUNT_BITS-1:0]  rdata;
  logic [COUNT_BITS-1:0]    old_exec, old_commit;

  alw_ram #(
    .WIDTH(2 * COUNT_BITS),
    .DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.upd),
    .waddr_i(ptr_q),
    .wdata_i({commit_count_i, exec_count_i}),
    .re_i   (ctrl_i.rd),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // never-written slots read as zero
  assign old_exec   = old_valid_q ? rdata[COUNT_BITS-1:0] : '0;
  assign old_commit = old_valid_q ? rdata[2*COUNT_BITS-1:COUNT_BITS] : '0;

  always_comb begin
    ptr_d           = ptr_q;
    valid_d         = valid_q;
    old_valid_d     = old_valid_q;
    exec_total_d    = exec_total_q;
    commit_total_d  = commit_total_q;
    commit_before_d = commit_before_q;
    if (ctrl_i.rd) begin
      old_valid_d = valid_q[ptr_q];
    end
    if (ctrl_i.upd) begin
      exec_total_d    = exec_total_q - TOTAL_BITS'(old_exec) + TOTAL_BITS'(exec_count_i);
      commit_total_d  = commit_total_q - TOTAL_BITS'(old_commit)
                        + TOTAL_BITS'(commit_count_i);
      commit_before_d = commit_total_q;
      valid_d[ptr_q]  = 1'b1;
      ptr_d = (ptr_q == PTR_BITS'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + PTR_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q           <= '0;
      valid_q         <= '0;
      old_valid_q     <= 1'b0;
      exec_total_q    <= '0;
      commit_total_q  <= '0;
      commit_before_q <= '0;
    end else begin
      ptr_q           <= ptr_d;
      valid_q         <= valid_d;
      old_valid_q     <= old_valid_d;
      exec_total_q    <= exec_total_d;
      commit_total_q  <= commit_total_d;
      commit_before_q <= commit_before_d;
    end
  end

  assign exec_total_o    = exec_total_q;
  assign commit_total_o  = commit_total_q;
  assign commit_before_o = commit_before_q;

endmodule

`default_nettype wire

[hw/rtl/alw_cdiv.sv]
// two-lane divider by the constants 100 and 101, one byte of quotient per cycle
// depends on alw_pkg
`timescale 1ns / 1ps
`default_nettype none

module alw_cdiv (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [alw_pkg::DIV_LANES-1:0][alw_pkg::DIV_WORD-1:0] dividend_i,
  output logic      [alw_pkg::DIV_LANES-1:0][alw_pkg::DIV_WORD-1:0] quotient_o,
  output logic      busy_o
);

  function automatic logic [alw_pkg::REM_BITS+alw_pkg::DIV_STEP-1:0] div_step(
    input logic [alw_pkg::REM_BITS-1:0] rem,
    input logic [alw_pkg::DIV_STEP-1:0] dig,
    input logic [alw_pkg::REM_BITS-1:0] dvs
  );
    logic [alw_pkg::REM_BITS:0]   r;
    logic [alw_pkg::REM_BITS-1:0] rr;
    logic [alw_pkg::DIV_STEP-1:0] q;
    rr = rem;
    q  = '0;
    for (int i = alw_pkg::DIV_STEP - 1; i >= 0; i--) begin
      r = {rr, dig[i]};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[i] = 1'b1;
      end
      rr = r[alw_pkg::REM_BITS-1:0];
    end
    return {rr, q};
  endfunction

  logic [alw_pkg::DIV_LANES-1:0][alw_pkg::DIV_WORD-1:0] work_q, work_d;
  logic [alw_pkg::DIV_LANES-1:0][alw_pkg::REM_BITS-1:0] rem_q, rem_d;
  logic [alw_pkg::DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [alw_pkg::REM_BITS+alw_pkg::DIV_STEP-1:0] step_res [alw_pkg::DIV_LANES];

  always_comb begin
    for (int l = 0; l < alw_pkg::DIV_LANES; l++) begin
      step_res[l] = div_step(rem_q[l],
                             work_q[l][alw_pkg::DIV_WORD-1 -: alw_pkg::DIV_STEP],
                             alw_pkg::DIV_CONST[l]);
    end
  end

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int l = 0; l < alw_pkg::DIV_LANES; l++) begin
        work_d[l] = {work_q[l][alw_pkg::DIV_WORD-alw_pkg::DIV_STEP-1:0],
                     step_res[l][alw_pkg::DIV_STEP-1:0]};
        rem_d[l]  = step_res[l][alw_pkg::REM_BITS+alw_pkg::DIV_STEP-1:alw_pkg::DIV_STEP];
      end
      cnt_d = cnt_q + alw_pkg::DIV_CNT_BITS'(1);
      if (cnt_q == alw_pkg::DIV_CNT_BITS'(alw_pkg::DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      work_q <= work_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign quotient_o = work_q;
  assign busy_o     = busy_q;

endmodule

`default_nettype wire

[hw/rtl/adaptive_lookahead_window.sv]
// adaptive lookahead window: an update round goes through the ring ram read, the rule, the constant
// divider and the clamp to its result; a bound-only item goes straight to the bound and clamp
// the state machine finishes one item before it takes the next from the input register
// an input register and an output register let a new item in while a result waits
// reset clears the ring valid bits and sums at once: width 1, direction up, end time all ones
// depends on alw_pkg, alw_hist and alw_cdiv
`timescale 1ns / 1ps
`default_nettype none

module adaptive_lookahead_window #(
  parameter int HISTORY_DEPTH = 16,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [63:0]  cfg_data_i,      // end_time
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,    // exec_count, commit_count, virtual_time
  input  wire logic [0:0]   s_axis_tuser,    // mode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata     // lookahead_bound, lookahead_width, growing
);

  localparam int TOTAL_BITS = COUNT_BITS + $clog2(HISTORY_DEPTH);
  localparam int PROD_BITS  = TOTAL_BITS + alw_pkg::PROD_EXTRA;
  localparam int WB = alw_pkg::WIDTH_BITS;
  localparam int TB = alw_pkg::TIME_BITS;
  localparam int FB = alw_pkg::FIELD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_RULE, S_DIV, S_WIDTH, S_BOUND
  } state_e;

  typedef enum logic [1:0] {
    R_SHRINK4, R_SHRINK2, R_GROW, R_MID
  } rule_e;

  state_e                state_q, state_d;
  rule_e                 rule_q, rule_d;
  logic                  in_full_q, in_full_d;
  logic                  in_mode_q, in_mode_d;
  logic [COUNT_BITS-1:0] in_ex_q, in_ex_d, in_cm_q, in_cm_d;
  logic [TB-1:0]         in_t_q, in_t_d;
  logic [COUNT_BITS-1:0] wk_ex_q, wk_ex_d, wk_cm_q, wk_cm_d;
  logic [TB-1:0]         wk_t_q, wk_t_d;
  logic [TB-1:0]         end_time_q, end_time_d;
  logic [WB-1:0]         width_q, width_d;
  logic                  dir_q, dir_d;
  logic                  out_valid_q, out_valid_d;
  logic [127:0]          out_data_q, out_data_d;

  alw_pkg::hist_ctrl_t   hctrl;
  logic [TOTAL_BITS-1:0] exec_total, commit_total, commit_before;
  logic                  div_start, div_busy;
  logic [alw_pkg::DIV_LANES-1:0][alw_pkg::DIV_WORD-1:0] div_in, div_q;

  logic [PROD_BITS-1:0]  c100, e33, e66, e95;
  logic [WB:0]           w_ext, wn, q_up, q_down;
  logic [TB:0]           sum;
  logic [TB-1:0]         bound;
  logic                  take, in_acc, out_load;

  alw_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .COUNT_BITS   (COUNT_BITS),
    .TOTAL_BITS   (TOTAL_BITS)
  ) u_hist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (hctrl),
    .exec_count_i   (wk_ex_q),
    .commit_count_i (wk_cm_q),
    .exec_total_o   (exec_total),
    .commit_total_o (commit_total),
    .commit_before_o(commit_before)
  );

  alw_cdiv u_cdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_in),
    .quotient_o(div_q),
    .busy_o    (div_busy)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !in_full_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign in_acc    = s_axis_tvalid && !in_full_q;
  assign take      = (state_q == S_IDLE) && in_full_q;
  assign div_start = take && !in_mode_q;
  assign hctrl.rd  = div_start;
  assign hctrl.upd = (state_q == S_READ);
  assign out_load  = (state_q == S_BOUND) && (!out_valid_q || m_axis_tready);

  // dividends: width for the upward step, width + 99 for the downward one
  always_comb begin
    div_in[alw_pkg::LANE_UP]   = alw_pkg::DIV_WORD'(width_q);
    div_in[alw_pkg::LANE_DOWN] = alw_pkg::DIV_WORD'(width_q)
                                 + alw_pkg::DIV_WORD'(alw_pkg::DOWN_BIAS);
  end

  assign c100 = PROD_BITS'(commit_total) * PROD_BITS'(alw_pkg::SCALE);
  assign e33  = PROD_BITS'(exec_total) * PROD_BITS'(alw_pkg::THR_LOW);
  assign e66  = PROD_BITS'(exec_total) * PROD_BITS'(alw_pkg::THR_MID);
  assign e95  = PROD_BITS'(exec_total) * PROD_BITS'(alw_pkg::THR_HIGH);

  assign w_ext  = {1'b0, width_q};
  assign q_up   = div_q[alw_pkg::LANE_UP][WB:0];
  assign q_down = div_q[alw_pkg::LANE_DOWN][WB:0];

  always_comb begin
    case (rule_q)
      R_SHRINK4: wn = w_ext >> 2;
      R_SHRINK2: wn = w_ext >> 1;
      R_GROW:    wn = w_ext << 1;
      default:   wn = dir_q ? (w_ext + (WB + 1)'(1) + q_up)
                            : (w_ext - (WB + 1)'(1) - q_down);
    endcase
  end

  assign sum = {1'b0, wk_t_q} + (TB + 1)'(width_q);
  always_comb begin
    bound = sum[TB] ? '1 : sum[TB-1:0];
    if (bound > end_time_q) begin
      bound = end_time_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    rule_d      = rule_q;
    in_full_d   = in_full_q;
    in_mode_d   = in_mode_q;
    in_ex_d     = in_ex_q;
    in_cm_d     = in_cm_q;
    in_t_d      = in_t_q;
    wk_ex_d     = wk_ex_q;
    wk_cm_d     = wk_cm_q;
    wk_t_d      = wk_t_q;
    end_time_d  = end_time_q;
    width_d     = width_q;
    dir_d       = dir_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_valid_i) begin
      end_time_d = cfg_data_i;
    end

    if (in_acc) begin
      in_full_d = 1'b1;
      in_mode_d = s_axis_tuser[0];
      in_ex_d   = COUNT_BITS'(s_axis_tdata[FB-1:0]);
      in_cm_d   = COUNT_BITS'(s_axis_tdata[2*FB-1:FB]);
      in_t_d    = s_axis_tdata[2*FB+TB-1:2*FB];
    end

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_full_q) begin
          in_full_d = 1'b0;
          wk_ex_d   = in_ex_q;
          wk_cm_d   = in_cm_q;
          wk_t_d    = in_t_q;
          state_d   = in_mode_q ? S_BOUND : S_READ;
        end
      end
      S_READ: begin
        state_d = S_RULE;
      end
      S_RULE: begin
        if (c100 < e66) begin
          rule_d = (c100 < e33) ? R_SHRINK4 : R_SHRINK2;
          dir_d  = 1'b0;
        end else if (c100 > e95) begin
          rule_d = R_GROW;
          dir_d  = 1'b1;
        end else begin
          rule_d = R_MID;
          if (commit_total < commit_before) begin
            dir_d = !dir_q;
          end
        end
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_WIDTH;
        end
      end
      S_WIDTH: begin
        if (wn > (WB + 1)'(alw_pkg::WIDTH_MAX)) begin
          width_d = alw_pkg::WIDTH_MAX;
        end else if (wn == '0) begin
          width_d = WB'(1);
        end else begin
          width_d = wn[WB-1:0];
        end
        state_d = S_BOUND;
      end
      S_BOUND: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0, dir_q, width_q, bound};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rule_q      <= R_MID;
      in_full_q   <= 1'b0;
      in_mode_q   <= 1'b0;
      in_ex_q     <= '0;
      in_cm_q     <= '0;
      in_t_q      <= '0;
      wk_ex_q     <= '0;
      wk_cm_q     <= '0;
      wk_t_q      <= '0;
      end_time_q  <= '1;
      width_q     <= WB'(1);
      dir_q       <= 1'b1;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      rule_q      <= rule_d;
      in_full_q   <= in_full_d;
      in_mode_q   <= in_mode_d;
      in_ex_q     <= in_ex_d;
      in_cm_q     <= in_cm_d;
      in_t_q      <= in_t_d;
      wk_ex_q     <= wk_ex_d;
      wk_cm_q     <= wk_cm_d;
      wk_t_q      <= wk_t_d;
      end_time_q  <= end_time_d;
      width_q     <= width_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule

`default_nettype wire

[bench/adaptive_lookahead_window_tb.sv]
// self-checking bench for adaptive_lookahead_window: directed and random rounds,
// each result checked against a built-in predictor of the window width, direction and bound
// depends on alw_pkg and the rtl of the block
`timescale 1ns / 1ps

module adaptive_lookahead_window_tb;

  localparam int RING_DEPTH    = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic {
    MODE_UPDATE     = 1'b0,
    MODE_BOUND_ONLY = 1'b1
  } round_mode_e;

  typedef enum int {
    BAND_HIGH,
    BAND_MIDDLE,
    BAND_HALVE,
    BAND_QUARTER,
    BAND_NOISE
  } band_e;

  typedef struct packed {
    logic                           growing;
    logic [alw_pkg::WIDTH_BITS-1:0] width;
    logic [alw_pkg::TIME_BITS-1:0]  bound;
  } bound_res_t;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [63:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata  = '0;
  logic [0:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  adaptive_lookahead_window u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state
  logic [alw_pkg::FIELD_BITS-1:0] exec_ring   [RING_DEPTH];
  logic [alw_pkg::FIELD_BITS-1:0] commit_ring [RING_DEPTH];
  logic [63:0]                    exec_sum;
  logic [63:0]                    commit_sum;
  int unsigned                    ring_slot;
  logic                           going_up;
  logic [alw_pkg::WIDTH_BITS-1:0] window_q;
  logic [alw_pkg::TIME_BITS-1:0]  end_time_q;

  bound_res_t  expected_bounds[$];
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_left      = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("adaptive_lookahead_window_tb: FAIL");
    $finish;
  end

  function automatic bound_res_t predict_round(round_mode_e mode, logic [31:0] ex,
                                               logic [31:0] cm, logic [63:0] t);
    logic [63:0] prior, w, x;
    logic [64:0] sum;
    bound_res_t  r;
    if (mode == MODE_UPDATE) begin
      prior      = commit_sum;
      exec_sum   = exec_sum - exec_ring[ring_slot] + ex;
      commit_sum = commit_sum - commit_ring[ring_slot] + cm;
      exec_ring[ring_slot]   = ex;
      commit_ring[ring_slot] = cm;
      ring_slot  = (ring_slot + 1) % RING_DEPTH;
      w = 64'(window_q);
      if (commit_sum * 64'd100 < exec_sum * 64'd66) begin
        if (commit_sum * 64'd100 < exec_sum * 64'd33) w = w / 4;
        else w = w / 2;
        going_up = 1'b0;
      end else if (commit_sum * 64'd100 > exec_sum * 64'd95) begin
        w = w * 2;
        going_up = 1'b1;
      end else begin
        if (commit_sum < prior) going_up = !going_up;
        if (going_up) begin
          w = 64'd1 + w + w / 100;
        end else begin
          x = w - 64'd1;
          w = x - (x + 64'd100) / 101;
        end
      end
      if (w > 64'(alw_pkg::WIDTH_MAX)) w = 64'(alw_pkg::WIDTH_MAX);
      if (w < 64'd1) w = 64'd1;
      window_q = w[alw_pkg::WIDTH_BITS-1:0];
    end
    sum = {1'b0, t} + 65'(window_q);
    r.bound   = sum[64] ? '1 : sum[63:0];
    if (r.bound > end_time_q) r.bound = end_time_q;
    r.width   = window_q;
    r.growing = going_up;
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic offer_round(round_mode_e mode, logic [31:0] ex, logic [31:0] cm,
                             logic [63:0] t);
    bound_res_t exp_res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, cm, ex};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_res = predict_round(mode, ex, cm, t);
    expected_bounds.insert(expected_bounds.size(), exp_res);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_bounds.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_end_time(logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    end_time_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_count();
    return $urandom >> $urandom_range(31, 0);
  endfunction

  function automatic logic [63:0] random_time();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return '1 - ({$urandom, $urandom} >> $urandom_range(63, 4));
      2: return {32'd0, $urandom};
      default: return '1;
    endcase
  endfunction

  task automatic test_directed_rounds();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    offer_round(MODE_BOUND_ONLY, '1, '1, 64'd0);
    // empty history takes the middle rule
    offer_round(MODE_UPDATE, 32'd0, 32'd0, 64'd0);
    // commits above executions
    offer_round(MODE_UPDATE, 32'd0, 32'd7, 64'd100);
    offer_round(MODE_UPDATE, '1, '1, '1);
    offer_round(MODE_UPDATE, 32'd1000, 32'd1200, '1 - 64'd3);
    // efficiency collapses, width driven to zero and clamped
    repeat (5) offer_round(MODE_UPDATE, '1, 32'd0, 64'h8000_0000_0000_0000);
    offer_round(MODE_BOUND_ONLY, '1, '1, '1 - 64'd1);
    offer_round(MODE_BOUND_ONLY, 32'd0, 32'd0, 64'h7fff_ffff_ffff_ffff);
    repeat (3) offer_round(MODE_UPDATE, '1, 32'hbd70_a3d7, 64'd12345);
    repeat (3) offer_round(MODE_UPDATE, '1, 32'h7fff_ffff, 64'd55);
    offer_round(MODE_UPDATE, 32'd0, '1, 64'd0);
    wait_drained();
  endtask

  task automatic test_end_time_cap();
    write_end_time(64'd0);
    offer_round(MODE_UPDATE, 32'd10, 32'd10, 64'd0);
    offer_round(MODE_BOUND_ONLY, 32'd0, 32'd0, '1);
    offer_round(MODE_UPDATE, 32'd20, 32'd20, 64'd77);
    wait_drained();
    write_end_time(64'h0000_0000_0000_1000);
    offer_round(MODE_UPDATE, 32'd30, 32'd30, 64'h0fe0);
    offer_round(MODE_BOUND_ONLY, 32'd0, 32'd0, 64'h0fff);
    offer_round(MODE_BOUND_ONLY, 32'd0, 32'd0, 64'h1000);
    offer_round(MODE_BOUND_ONLY, 32'd0, 32'd0, 64'h0001);
    wait_drained();
    write_end_time('1);
  endtask

  task automatic test_random_rounds(int unsigned rounds, int unsigned idle,
                                    int unsigned stall, logic [63:0] end_time);
    band_e       band;
    int unsigned streak;
    int unsigned pct;
    logic [31:0] ex;
    logic [63:0] scaled;
    write_end_time(end_time);
    send_idle_pct  = idle;
    sink_stall_pct = stall;
    streak = 0;
    band   = BAND_NOISE;
    for (int unsigned n = 0; n < rounds; n++) begin
      if (streak == 0) begin
        band   = band_e'($urandom_range(BAND_NOISE, BAND_HIGH));
        streak = (band == BAND_HIGH) ? $urandom_range(80, 1) : $urandom_range(24, 1);
      end
      streak--;
      if ($urandom_range(99) < 15) begin
        offer_round(MODE_BOUND_ONLY, $urandom, $urandom, random_time());
      end else if (band == BAND_NOISE) begin
        offer_round(MODE_UPDATE, $urandom, random_count(), random_time());
      end else begin
        case (band)
          BAND_HIGH:   pct = $urandom_range(130, 96);
          BAND_MIDDLE: pct = $urandom_range(94, 67);
          BAND_HALVE:  pct = $urandom_range(65, 34);
          default:     pct = $urandom_range(32, 0);
        endcase
        ex     = random_count();
        scaled = 64'(ex) * 64'(pct) / 100;
        offer_round(MODE_UPDATE, ex, (scaled > 64'hffff_ffff) ? '1 : scaled[31:0],
                    random_time());
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (48) offer_round($urandom_range(99) < 20 ? MODE_BOUND_ONLY : MODE_UPDATE,
                            random_count(), random_count(), random_time());
    wait_drained();
  endtask

  // receiver side: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bound_res_t got;
    bound_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = bound_res_t'(m_axis_tdata[123:0]);
      if (expected_bounds.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
      end else begin
        want = expected_bounds.pop_front();
        if (got.bound !== want.bound) begin
          fail_count++;
          $display("%0t: lookahead_bound expected %h actual %h", $time, want.bound,
                   got.bound);
        end
        if (got.width !== want.width) begin
          fail_count++;
          $display("%0t: lookahead_width expected %h actual %h", $time, want.width,
                   got.width);
        end
        if (got.growing !== want.growing) begin
          fail_count++;
          $display("%0t: growing expected %b actual %b", $time, want.growing,
                   got.growing);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      exec_ring[i]   = '0;
      commit_ring[i] = '0;
    end
    exec_sum   = '0;
    commit_sum = '0;
    ring_slot  = 0;
    going_up   = 1'b1;
    window_q   = alw_pkg::WIDTH_BITS'(1);
    end_time_q = '1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_rounds();
    test_end_time_cap();
    test_random_rounds(230, 0, 0, '1);
    test_random_rounds(230, 67, 0, {$urandom, $urandom});
    test_random_rounds(230, 0, 67, {1'b1, 31'($urandom), $urandom});
    test_random_rounds(230, 35, 35, '1);
    test_backpressure();

    if (fail_count == 0) begin
      $display("adaptive_lookahead_window_tb: PASS");
    end else begin
      $display("adaptive_lookahead_window_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/alw_pkg.sv
hw/rtl/alw_ram.sv
hw/rtl/alw_hist.sv
hw/rtl/alw_cdiv.sv
hw/rtl/adaptive_lookahead_window.sv
bench/adaptive_lookahead_window_tb.sv
